// ===== hw/rtl/tdse_pkg.sv =====
// Shared types, widths and codes for the tiled dense-to-sparse encoder.
package tdse_pkg;

  localparam int DEF_MAX_DIM   = 1024;
  localparam int DEF_MAX_TILES = 8;

  localparam int IN_W        = 64;
  localparam int VAL_W       = 64;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 21;
  localparam int KIND_W      = 2;
  localparam int DIM_REG_W   = 11;
  localparam int TILE_REG_W  = 4;
  localparam int MODE_W      = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_FIELD_W = VAL_W + IDX_W + IDX_W + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_ACROSS = 3'd2,
    REG_DOWN   = 3'd3,
    REG_MODE   = 3'd4
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CSC  = 2'd0,
    MODE_CSR  = 2'd1,
    MODE_LIST = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PTR   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_FINAL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [DIM_REG_W-1:0]  rows;
    logic [DIM_REG_W-1:0]  cols;
    logic [TILE_REG_W-1:0] across;
    logic [TILE_REG_W-1:0] down;
    logic [MODE_W-1:0]     mode;
  } cfg_t;

  // One classified item: which records it causes and what they carry.
  typedef struct packed {
    logic             has_ptr;
    logic             has_nz;
    logic             has_fin;
    logic             mend;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] minor;
    logic [IDX_W-1:0] y;
    logic [CNT_W-1:0] count;
  } qitem_t;

endpackage

// ===== hw/rtl/tdse_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module tdse_divider
  import tdse_pkg::*;
#(
  parameter int NUM_W = 11,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic              active;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [NUM_W:0]    quo_shift;

  assign trial     = {rem, quo[NUM_W-1]};
  assign ge        = trial >= {1'b0, den};
  assign diff      = trial - {1'b0, den};
  assign quo_shift = {quo, ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      steps  <= '0;
    end else if (start) begin
      active <= 1'b1;
      steps  <= STEP_W'(NUM_W);
    end else if (active) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numer;
      rem <= '0;
      den <= denom;
    end else if (active) begin
      quo <= quo_shift[NUM_W-1:0];
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy     = active;
  assign quotient = quo;

  a_steps_live: assert property (@(posedge clk) disable iff (rst)
    active |-> steps != '0)
    else $error("divider active with no steps left");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !active)
    else $error("divider restarted while busy");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    active && steps == STEP_W'(1) && !start |=> !active)
    else $error("divider did not finish on its last step");

endmodule

// ===== hw/rtl/tdse_front.sv =====
// Front end: sizes the tiles, walks positions and classifies each item.
module tdse_front
  import tdse_pkg::*;
#(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int MAX_TILES = DEF_MAX_TILES
) (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  output logic            push,
  output qitem_t          push_item,
  input  logic            q_full
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int TP_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int TCNT_W  = $clog2(MAX_TILES + 1);
  localparam int BASE_W  = $clog2(MAX_DIM + MAX_TILES + 1);
  localparam int NUM_W   = $clog2(MAX_DIM + MAX_TILES);
  localparam int CMPD_W  = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam int CMPT_W  = (TCNT_W > TILE_REG_W) ? TCNT_W : TILE_REG_W;
  localparam int XW      = POS_W + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIVIDE = 3'b010,
    S_RUN    = 3'b100
  } fstate_t;

  fstate_t           state;
  logic [DIM_W-1:0]  run_rows;
  logic [DIM_W-1:0]  run_cols;
  logic [TCNT_W-1:0] run_across;
  logic [TCNT_W-1:0] run_down;
  mode_t             run_mode;
  logic [DIM_W-1:0]  tile_height;
  logic [DIM_W-1:0]  tile_width;
  logic [TP_W-1:0]   tile_row_pos;
  logic [TP_W-1:0]   tile_col_pos;
  logic [BASE_W-1:0] row_base;
  logic [BASE_W-1:0] col_base;
  logic [POS_W-1:0]  outer_pos;
  logic [POS_W-1:0]  inner_pos;
  logic [CNT_W-1:0]  nonzero_count;

  // clamped configuration
  logic [CMPD_W-1:0] rows_x, cols_x, rows_c, cols_c;
  logic [CMPT_W-1:0] across_x, down_x, across_c, down_c;
  mode_t             mode_c;

  logic              start;
  logic              h_busy, w_busy;
  logic [NUM_W-1:0]  h_quo, w_quo;

  logic              csc, list;
  logic [POS_W-1:0]  lr, lc;
  logic [BASE_W-1:0] gr, gc;
  logic              inr, inc, nonzero;
  logic [DIM_W-1:0]  inner_lim, outer_lim;
  logic              inner_last, outer_last, col_last, row_last;
  logic              has_ptr, has_nz, has_fin;
  logic              accept;
  logic [XW-1:0]     lr_x, lc_x;

  assign rows_x   = CMPD_W'(cfg.rows);
  assign cols_x   = CMPD_W'(cfg.cols);
  assign across_x = CMPT_W'(cfg.across);
  assign down_x   = CMPT_W'(cfg.down);
  assign rows_c   = (rows_x == '0) ? CMPD_W'(1) :
                    (rows_x > CMPD_W'(MAX_DIM)) ? CMPD_W'(MAX_DIM) : rows_x;
  assign cols_c   = (cols_x == '0) ? CMPD_W'(1) :
                    (cols_x > CMPD_W'(MAX_DIM)) ? CMPD_W'(MAX_DIM) : cols_x;
  assign across_c = (across_x == '0) ? CMPT_W'(1) :
                    (across_x > CMPT_W'(MAX_TILES)) ? CMPT_W'(MAX_TILES) : across_x;
  assign down_c   = (down_x == '0) ? CMPT_W'(1) :
                    (down_x > CMPT_W'(MAX_TILES)) ? CMPT_W'(MAX_TILES) : down_x;
  assign mode_c   = (cfg.mode > MODE_LIST) ? MODE_LIST : mode_t'(cfg.mode);

  assign start = (state == S_IDLE) && s_tvalid;

  tdse_divider #(.NUM_W(NUM_W), .DEN_W(TCNT_W)) u_div_h (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .numer    (NUM_W'(rows_c) + NUM_W'(down_c) - NUM_W'(1)),
    .denom    (TCNT_W'(down_c)),
    .busy     (h_busy),
    .quotient (h_quo)
  );

  tdse_divider #(.NUM_W(NUM_W), .DEN_W(TCNT_W)) u_div_w (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .numer    (NUM_W'(cols_c) + NUM_W'(across_c) - NUM_W'(1)),
    .denom    (TCNT_W'(across_c)),
    .busy     (w_busy),
    .quotient (w_quo)
  );

  // classify the item at the current position
  assign csc     = (run_mode == MODE_CSC);
  assign list    = (run_mode == MODE_LIST);
  assign lr      = csc ? inner_pos : outer_pos;
  assign lc      = csc ? outer_pos : inner_pos;
  assign gr      = row_base + BASE_W'(lr);
  assign gc      = col_base + BASE_W'(lc);
  assign inr     = gr < BASE_W'(run_rows);
  assign inc     = gc < BASE_W'(run_cols);
  assign nonzero = s_tdata[IN_W-2:0] != '0;

  assign inner_lim  = csc ? tile_height : tile_width;
  assign outer_lim  = csc ? tile_width : tile_height;
  assign inner_last = (DIM_W'(inner_pos) + DIM_W'(1)) == inner_lim;
  assign outer_last = (DIM_W'(outer_pos) + DIM_W'(1)) == outer_lim;
  assign col_last   = (TCNT_W'(tile_col_pos) + TCNT_W'(1)) == run_across;
  assign row_last   = (TCNT_W'(tile_row_pos) + TCNT_W'(1)) == run_down;

  assign has_ptr = (inner_pos == '0) && !list && (csc ? inc : inr);
  assign has_nz  = inr && inc && nonzero;
  assign has_fin = inner_last && outer_last;

  assign lr_x = XW'(lr);
  assign lc_x = XW'(lc);

  assign s_tready = (state == S_RUN) && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (has_ptr || has_nz || has_fin);

  always_comb begin
    push_item         = '0;
    push_item.has_ptr = has_ptr;
    push_item.has_nz  = has_nz;
    push_item.has_fin = has_fin;
    push_item.mend    = col_last && row_last;
    push_item.value   = s_tdata;
    push_item.minor   = csc ? lr_x[IDX_W-1:0] : lc_x[IDX_W-1:0];
    push_item.y       = list ? lr_x[IDX_W-1:0] : '0;
    push_item.count   = nonzero_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      run_rows      <= DIM_W'(1);
      run_cols      <= DIM_W'(1);
      run_across    <= TCNT_W'(1);
      run_down      <= TCNT_W'(1);
      run_mode      <= MODE_CSR;
      tile_height   <= '0;
      tile_width    <= '0;
      tile_row_pos  <= '0;
      tile_col_pos  <= '0;
      row_base      <= '0;
      col_base      <= '0;
      outer_pos     <= '0;
      inner_pos     <= '0;
      nonzero_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            run_rows      <= DIM_W'(rows_c);
            run_cols      <= DIM_W'(cols_c);
            run_across    <= TCNT_W'(across_c);
            run_down      <= TCNT_W'(down_c);
            run_mode      <= mode_c;
            tile_row_pos  <= '0;
            tile_col_pos  <= '0;
            row_base      <= '0;
            col_base      <= '0;
            outer_pos     <= '0;
            inner_pos     <= '0;
            nonzero_count <= '0;
            state         <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (!h_busy && !w_busy) begin
            tile_height <= DIM_W'(h_quo);
            tile_width  <= DIM_W'(w_quo);
            state       <= S_RUN;
          end
        end
        S_RUN: begin
          if (accept) begin
            nonzero_count <= has_fin ? '0 : nonzero_count + CNT_W'(has_nz);
            if (!inner_last) begin
              inner_pos <= inner_pos + POS_W'(1);
            end else begin
              inner_pos <= '0;
              if (!outer_last) begin
                outer_pos <= outer_pos + POS_W'(1);
              end else begin
                outer_pos <= '0;
                if (!col_last) begin
                  tile_col_pos <= tile_col_pos + TP_W'(1);
                  col_base     <= col_base + BASE_W'(tile_width);
                end else begin
                  tile_col_pos <= '0;
                  col_base     <= '0;
                  if (!row_last) begin
                    tile_row_pos <= tile_row_pos + TP_W'(1);
                    row_base     <= row_base + BASE_W'(tile_height);
                  end else begin
                    // last tile done: back to idle, next item starts a new matrix
                    tile_row_pos <= '0;
                    row_base     <= '0;
                    state        <= S_IDLE;
                  end
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_run: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_RUN)
    else $error("input ready outside run state");
  a_inner_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> DIM_W'(inner_pos) < inner_lim)
    else $error("inner position beyond tile edge");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into a full queue");
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    push && push_item.has_fin && push_item.mend |=> state == S_IDLE)
    else $error("matrix end did not return to idle");

endmodule

// ===== hw/rtl/tdse_queue.sv =====
// Short item queue between the front end and the record emitter.
module tdse_queue
  import tdse_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output qitem_t head,
  output logic   empty
);

  qitem_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = fill == QCNT_W'(QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from an empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill out of range");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + QCNT_W'(1))
    else $error("queue fill did not advance on push");

endmodule

// ===== hw/rtl/tdse_back.sv =====
// Back end: expands each queued item into its records, one per cycle unless stalled.
module tdse_back
  import tdse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  qitem_t                 head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]      m_tuser,
  output logic                   m_tlast
);

  localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  logic [2:0]       done;
  logic [2:0]       pend;
  logic [2:0]       sel;
  logic [2:0]       rest;
  logic             load;

  kind_t            out_kind;
  logic [VAL_W-1:0] out_value;
  logic [IDX_W-1:0] out_minor;
  logic [IDX_W-1:0] out_y;
  logic [CNT_W-1:0] out_count;
  logic             out_mend;
  logic             out_last;

  // bit 0 pointer, bit 1 entry, bit 2 final
  assign pend = {head.has_fin, head.has_nz, head.has_ptr} & ~done & {3{!empty}};
  assign sel  = pend[0] ? 3'b001 : (pend[1] ? 3'b010 : (pend[2] ? 3'b100 : 3'b000));
  assign rest = pend & ~sel;
  assign load = (pend != '0) && (!m_tvalid || m_tready);
  assign pop  = load && (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        done <= '0;
      end else if (load) begin
        done <= done | sel;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_last  <= rest == '0;
      out_kind  <= sel[0] ? KIND_PTR : (sel[1] ? KIND_ENTRY : KIND_FINAL);
      out_value <= sel[1] ? head.value : '0;
      out_minor <= sel[1] ? head.minor : '0;
      out_y     <= sel[1] ? head.y : '0;
      out_count <= sel[0] ? head.count :
                   (sel[2] ? head.count + CNT_W'(head.has_nz) : '0);
      out_mend  <= sel[2] && head.mend;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_mend, out_count, out_y, out_minor, out_value};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    load |-> $onehot(sel))
    else $error("record select not one-hot");
  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (done & ~{head.has_fin, head.has_nz, head.has_ptr}) == '0)
    else $error("done mask covers a record the item lacks");
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind == KIND_FINAL |-> out_last)
    else $error("tile-final record not last of its item");

endmodule

// ===== hw/rtl/tiled_dense_to_sparse_encoder.sv =====
// Top level of the tiled dense-to-sparse encoder: config registers and stage wiring.
//
//   port group   direction  handshake          contents
//   s_t*         in         tvalid/tready      tdata: element_bits
//   m_t*         out        tvalid/tready      tdata/tuser/tlast: one record
//   cfg_*        in         cfg_we             cfg_index selects, cfg_data value
//
// In a running matrix one item is taken per cycle while the queue is not full; the
// record stage sends one record per cycle while m_tready allows, and an item with two
// or three records stays at the queue head until its last record is loaded. The first
// item of each matrix waits while the two dividers size the tiles.
// A four-item queue lets the input run on while the output stalls.
// Reset clears all control state and loads every config register with 1.
module tiled_dense_to_sparse_encoder
  import tdse_pkg::*;
#(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int MAX_TILES = DEF_MAX_TILES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,   // [63:0] element_bits
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [63:0] value_bits, [73:64] minor_index, [83:74] y_index,
  // [104:84] pointer_count, [105] matrix_end, [111:106] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]      m_tuser,   // [1:0] record_kind
  output logic                   m_tlast    // last_of_run
);

  cfg_t   cfg;
  logic   push;
  qitem_t push_item;
  logic   q_full;
  logic   pop;
  qitem_t head;
  logic   q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows   <= DIM_REG_W'(1);
      cfg.cols   <= DIM_REG_W'(1);
      cfg.across <= TILE_REG_W'(1);
      cfg.down   <= TILE_REG_W'(1);
      cfg.mode   <= MODE_CSR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:   cfg.rows   <= cfg_data[DIM_REG_W-1:0];
        REG_COLS:   cfg.cols   <= cfg_data[DIM_REG_W-1:0];
        REG_ACROSS: cfg.across <= cfg_data[TILE_REG_W-1:0];
        REG_DOWN:   cfg.down   <= cfg_data[TILE_REG_W-1:0];
        REG_MODE:   cfg.mode   <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  tdse_front #(.MAX_DIM(MAX_DIM), .MAX_TILES(MAX_TILES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  tdse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  tdse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
